// File: hdl/mrd_pkg.sv
// shared types, constants and crc helper for the modbus rtu response decoder
package mrd_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 64;
    localparam int MAX_DATA_BYTES_DEF  = 32;
    localparam int RESULT_LIMIT        = 32;

    // result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_CRC   = 2'd1;
    localparam logic [1:0] STAT_PROTO = 2'd2;
    localparam logic [1:0] STAT_LEN   = 2'd3;

    // supported function codes
    localparam logic [7:0] FC_READ_COILS    = 8'd1;
    localparam logic [7:0] FC_READ_DISCRETE = 8'd2;
    localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
    localparam logic [7:0] FC_READ_INPUT    = 8'd4;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // summary of a received frame, handed from receive side to decoder
    typedef struct packed {
        logic        ovf;
        logic        lt4;
        logic        lt5;
        logic        bc_over_len;
        logic [7:0]  code;
        logic [7:0]  bc;
        logic [15:0] crc;
        logic [15:0] got;
        logic [15:0] base;
    } frame_sum_t;

    // one byte of the reflected modbus crc
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// File: hdl/modbus_rtu_response_decoder_unit.sv
// top level of the modbus rtu response decoder
// input: one byte per cycle while receiving; tready drops from the frame end transaction
// until the frame's last result sits in the output register
// after the frame end transaction the sequencer passes DECIDE, then PUT for a status result;
// a coil result passes RD0, RD1 and PUT, a register result RD0, RD1, RD2 and PUT
// reset: counters, crc and sequencer clear at once; the frame store is not cleared
module modbus_rtu_response_decoder_unit #(
    parameter int MAX_FRAME_BYTES = mrd_pkg::MAX_FRAME_BYTES_DEF,
    parameter int MAX_DATA_BYTES  = mrd_pkg::MAX_DATA_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // rx_byte[7:0], dest_base[23:8]
    input  logic        s_axis_tlast,   // frame_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // dest_index[15:0], value[31:16]
    output logic [3:0]  m_axis_tuser,   // status[1:0], write_valid[2], is_bits[3]
    output logic        m_axis_tlast    // last
);
    import mrd_pkg::*;

    localparam int AW = $clog2(MAX_FRAME_BYTES);

    logic          accept;
    logic          idle;
    logic          clear;
    logic          frame_done;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;
    frame_sum_t    summary;

    // bytes are taken only while the sequencer waits for a frame
    assign s_axis_tready = idle;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // byte counting, overflow, running crc over all but the last two bytes
    mrd_rx_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .rx_byte    (s_axis_tdata[7:0]),
        .frame_end  (s_axis_tlast),
        .dest_base  (s_axis_tdata[23:8]),
        .clear      (clear),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .frame_done (frame_done),
        .summary    (summary)
    );

    // frame bytes, read back by the sequencer for the data payload
    mrd_frame_mem #(
        .DEPTH(MAX_FRAME_BYTES)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // checks crc, code and length, then walks the data bytes into results
    mrd_decode_ctrl #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_done (frame_done),
        .summary    (summary),
        .rd_data    (mem_rdata),
        .rd_addr    (mem_raddr),
        .clear      (clear),
        .idle       (idle),
        .m_tvalid   (m_axis_tvalid),
        .m_tready   (m_axis_tready),
        .m_tdata    (m_axis_tdata),
        .m_tuser    (m_axis_tuser),
        .m_tlast    (m_axis_tlast)
    );

endmodule

// File: hdl/mrd_frame_mem.sv
// frame byte store: one write port, one registered read port
module mrd_frame_mem #(
    parameter int DEPTH = mrd_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [7:0]               wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [7:0]               rdata
);
    import mrd_pkg::*;

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/mrd_rx_front.sv
// receive side: byte count, overflow, running crc and header capture
module mrd_rx_front #(
    parameter int MAX_FRAME_BYTES = mrd_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  logic [7:0]                         rx_byte,
    input  logic                               frame_end,
    input  logic [15:0]                        dest_base,
    input  logic                               clear,
    output logic                               mem_we,
    output logic [$clog2(MAX_FRAME_BYTES)-1:0] mem_waddr,
    output logic [7:0]                         mem_wdata,
    output logic                               frame_done,
    output mrd_pkg::frame_sum_t                summary
);
    import mrd_pkg::*;

    localparam int AW = $clog2(MAX_FRAME_BYTES);
    localparam int CW = $clog2(MAX_FRAME_BYTES + 1);

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [15:0]   crc_reg, crc_next;
    logic [7:0]    b1_reg, b2_reg;
    logic [7:0]    code_reg, bc_reg;
    logic [15:0]   base_reg;
    logic          store;
    logic [9:0]    bc_plus5;

    assign store = accept && (count_reg < CW'(MAX_FRAME_BYTES));

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        crc_next   = crc_reg;
        if (clear)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
            crc_next   = CRC_INIT;
        end
        else if (store)
        begin
            count_next = count_reg + CW'(1);
            // byte two places back joins the crc, the last two stay out
            if (count_reg >= CW'(2))
                crc_next = crc16_byte(crc_reg, b2_reg);
        end
        else if (accept)
        begin
            ovf_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            crc_reg   <= CRC_INIT;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            crc_reg   <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            b1_reg <= rx_byte;
            b2_reg <= b1_reg;
            if (count_reg == CW'(1))
                code_reg <= rx_byte;
            if (count_reg == CW'(2))
                bc_reg <= rx_byte;
        end
        if (accept && frame_end)
        begin
            base_reg <= dest_base;
        end
    end

    assign mem_we     = store;
    assign mem_waddr  = count_reg[AW-1:0];
    assign mem_wdata  = rx_byte;
    assign frame_done = accept && frame_end;

    assign bc_plus5 = {2'b00, bc_reg} + 10'd5;

    always_comb
    begin
        summary.ovf         = ovf_reg;
        summary.lt4         = count_reg < CW'(4);
        summary.lt5         = count_reg < CW'(5);
        summary.bc_over_len = bc_plus5 > 10'(count_reg);
        summary.code        = code_reg;
        summary.bc          = bc_reg;
        summary.crc         = crc_reg;
        summary.got         = {b2_reg, b1_reg};
        summary.base        = base_reg;
    end

endmodule

// File: hdl/mrd_decode_ctrl.sv
// frame check and result sequencer reading the frame store
module mrd_decode_ctrl #(
    parameter int MAX_FRAME_BYTES = mrd_pkg::MAX_FRAME_BYTES_DEF,
    parameter int MAX_DATA_BYTES  = mrd_pkg::MAX_DATA_BYTES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               frame_done,
    input  mrd_pkg::frame_sum_t                summary,
    input  logic [7:0]                         rd_data,
    output logic [$clog2(MAX_FRAME_BYTES)-1:0] rd_addr,
    output logic                               clear,
    output logic                               idle,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [31:0]                        m_tdata,
    output logic [3:0]                         m_tuser,
    output logic                               m_tlast
);
    import mrd_pkg::*;

    localparam int AW = $clog2(MAX_FRAME_BYTES);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECIDE = 6'b000010,
        S_RD0    = 6'b000100,
        S_RD1    = 6'b001000,
        S_RD2    = 6'b010000,
        S_PUT    = 6'b100000
    } state_t;

    state_t      state_reg, state_next;
    logic [5:0]  idx_reg, idx_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        bits_reg, bits_next;
    logic [7:0]  hi_reg;
    logic        out_valid_reg, out_valid_next;

    // staged result, waiting for the output register
    logic [1:0]  st_stat_reg, st_stat_next;
    logic        st_wv_reg, st_wv_next;
    logic        st_bits_reg, st_bits_next;
    logic [15:0] st_idx_reg, st_idx_next;
    logic [15:0] st_val_reg, st_val_next;
    logic        st_last_reg, st_last_next;

    logic [1:0]  o_stat_reg;
    logic        o_wv_reg, o_bits_reg, o_last_reg;
    logic [15:0] o_idx_reg, o_val_reg;

    logic        load_out;
    logic        err;
    logic [1:0]  err_stat;
    logic [7:0]  addr_full;
    logic [15:0] dest_calc;
    logic        is_last;

    // error checks in priority order
    always_comb
    begin
        err      = 1'b1;
        err_stat = STAT_LEN;
        if (summary.ovf || summary.lt4)
            err_stat = STAT_LEN;
        else if (summary.got != {summary.crc[7:0], summary.crc[15:8]})
            err_stat = STAT_CRC;
        else if (!(summary.code inside {[FC_READ_COILS:FC_READ_INPUT]}))
            err_stat = STAT_PROTO;
        else if (summary.lt5 || summary.bc_over_len ||
                 summary.bc > 8'(MAX_DATA_BYTES) || summary.bc > 8'(RESULT_LIMIT))
            err_stat = STAT_LEN;
        else
        begin
            err      = 1'b0;
            err_stat = STAT_OK;
        end
    end

    // data byte address: coil byte i at 3+i, word i at 3+2i and 4+2i
    assign addr_full = 8'd3 + (bits_reg ? {2'b00, idx_reg} : {1'b0, idx_reg, 1'b0})
                       + ((state_reg == S_RD1) ? 8'd1 : 8'd0);
    assign rd_addr   = addr_full[AW-1:0];

    assign dest_calc = summary.base +
                       (bits_reg ? {7'b0, idx_reg, 3'b000} : {10'b0, idx_reg});
    assign is_last   = (idx_reg + 6'd1) == cnt_reg;

    assign load_out = (state_reg == S_PUT) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        bits_next      = bits_reg;
        st_stat_next   = st_stat_reg;
        st_wv_next     = st_wv_reg;
        st_bits_next   = st_bits_reg;
        st_idx_next    = st_idx_reg;
        st_val_next    = st_val_reg;
        st_last_next   = st_last_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (load_out)
            out_valid_next = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (frame_done)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                st_stat_next = err_stat;
                st_wv_next   = 1'b0;
                st_bits_next = 1'b0;
                st_idx_next  = '0;
                st_val_next  = '0;
                st_last_next = 1'b1;
                if (err || summary.bc == 8'd0)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    bits_next  = summary.code inside {FC_READ_COILS, FC_READ_DISCRETE};
                    cnt_next   = bits_next ? summary.bc[5:0]
                                           : 6'((summary.bc + 8'd1) >> 1);
                    idx_next   = '0;
                    state_next = S_RD0;
                end
            end
            S_RD0:
            begin
                state_next = S_RD1;
            end
            S_RD1:
            begin
                st_stat_next = STAT_OK;
                st_wv_next   = 1'b1;
                st_bits_next = bits_reg;
                st_idx_next  = dest_calc;
                st_last_next = is_last;
                st_val_next  = {8'h00, rd_data};
                state_next   = bits_reg ? S_PUT : S_RD2;
            end
            S_RD2:
            begin
                st_val_next = {hi_reg, rd_data};
                state_next  = S_PUT;
            end
            S_PUT:
            begin
                if (load_out)
                begin
                    if (st_last_reg)
                        state_next = S_IDLE;
                    else
                    begin
                        idx_next   = idx_reg + 6'd1;
                        state_next = S_RD0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            bits_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            bits_reg      <= bits_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_stat_reg <= st_stat_next;
        st_wv_reg   <= st_wv_next;
        st_bits_reg <= st_bits_next;
        st_idx_reg  <= st_idx_next;
        st_val_reg  <= st_val_next;
        st_last_reg <= st_last_next;
        if (state_reg == S_RD1)
            hi_reg <= rd_data;
        if (load_out)
        begin
            o_stat_reg <= st_stat_reg;
            o_wv_reg   <= st_wv_reg;
            o_bits_reg <= st_bits_reg;
            o_idx_reg  <= st_idx_reg;
            o_val_reg  <= st_val_reg;
            o_last_reg <= st_last_reg;
        end
    end

    assign clear    = (state_reg == S_DECIDE);
    assign idle     = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {o_val_reg, o_idx_reg};
    assign m_tuser  = {o_bits_reg, o_wv_reg, o_stat_reg};
    assign m_tlast  = o_last_reg;

endmodule
